### sv/bcnt_pkg.sv
// Shared types and constants for the bucketed checksum name table.
`timescale 1ns / 1ps
package bcnt_pkg;

    localparam int KEY_W     = 32;
    localparam int LEN_W     = 22;
    localparam int OFF_OUT_W = 22;
    localparam int USED_W    = 23;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED    = 3'd0,
        ST_FOUND       = 3'd1,
        ST_NOT_FOUND   = 3'd2,
        ST_BUCKET_FULL = 3'd3,
        ST_STORE_FULL  = 3'd4,
        ST_ZERO_KEY    = 3'd5
    } t_status;

    typedef struct packed {
        logic hit;
        logic free_found;
    } t_scan_flags;

endpackage

### sv/bcnt_scan.sv
// Parallel key compare and first-free-slot search over one bucket row.
`timescale 1ns / 1ps
module bcnt_scan #(
    parameter int SLOTS = 10,
    parameter int OFF_W = 22,
    parameter int IDX_W = 4
) (
    input  logic [SLOTS-1:0]                         i_valid,
    input  logic [SLOTS-1:0][bcnt_pkg::KEY_W-1:0]    i_keys,
    input  logic [SLOTS-1:0][OFF_W-1:0]              i_offs,
    input  logic [bcnt_pkg::KEY_W-1:0]               i_key,
    output bcnt_pkg::t_scan_flags                    o_flags,
    output logic [OFF_W-1:0]                         o_hit_offset,
    output logic [IDX_W-1:0]                         o_free_idx
);
    import bcnt_pkg::*;

    // Slots fill in order and are never freed, so the valid slots form a
    // prefix of the row. A key is unique within its bucket, so any valid
    // match is the one the scan would stop at.
    always_comb begin
        o_flags      = '0;
        o_hit_offset = '0;
        o_free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (i_valid[i] && (i_keys[i] == i_key)) begin
                o_flags.hit  = 1'b1;
                o_hit_offset = i_offs[i];
            end
            if (!i_valid[i]) begin
                o_flags.free_found = 1'b1;
                o_free_idx         = IDX_W'(i);
            end
        end
    end

endmodule

### sv/bucketed_checksum_name_table.sv
// Top level of the bucketed checksum name table.
`timescale 1ns / 1ps
// Usage:
// A request is taken at a rising edge where start is high and busy is low; the
// beat carries i_cmd (insert or lookup), i_key and i_name_length. The low
// HASH_BITS bits of the key pick one bucket row of SLOTS_PER_BUCKET slots.
// The row is read in the accept cycle, compared, and for an insert written back,
// in the next cycle, and the result beat (o_status, o_name_offset, o_store_used)
// shows on the ports with o_strobe for exactly one cycle after that. Busy is
// high during the check cycle, so a new request is not taken until the
// current one has been checked and its result registered.
// A new request may be taken in the same cycle that a result is presented.
// The receiver cannot stall: each result beat is taken as presented.
// After reset the block clears the bucket memory one row per cycle; busy stays
// high until every row is cleared.
// The enable register (i_cfg_we, i_cfg_wdata) resets to one and may be
// written at any edge while no request is in flight.
module bucketed_checksum_name_table #(
    parameter int HASH_BITS        = 12,
    parameter int SLOTS_PER_BUCKET = 10,
    parameter int NAME_STORE_BYTES = 4194304
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cmd,
    input  logic [bcnt_pkg::KEY_W-1:0]        i_key,
    input  logic [bcnt_pkg::LEN_W-1:0]        i_name_length,
    output logic                              o_strobe,
    output bcnt_pkg::t_status                 o_status,
    output logic [bcnt_pkg::OFF_OUT_W-1:0]    o_name_offset,
    output logic [bcnt_pkg::USED_W-1:0]       o_store_used,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata
);
    import bcnt_pkg::*;

    localparam int ROWS  = 1 << HASH_BITS;
    localparam int S     = SLOTS_PER_BUCKET;
    localparam int OFF_W = $clog2(NAME_STORE_BYTES);
    localparam int FP_W  = $clog2(NAME_STORE_BYTES + 1);
    localparam int IDX_W = (S > 1) ? $clog2(S) : 1;
    localparam int SUM_W = ((FP_W > LEN_W) ? FP_W : LEN_W) + 1;
    localparam int ROW_W = S * (1 + KEY_W + OFF_W);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK
    } t_state;

    t_state                  r_state;
    logic [HASH_BITS-1:0]    r_clr_row;
    logic                    r_enable;
    logic [FP_W-1:0]         r_fp;
    logic                    r_cmd;
    logic [KEY_W-1:0]        r_key;
    logic [LEN_W-1:0]        r_len;
    logic [ROW_W-1:0]        r_rd_row;
    logic                    r_strobe;
    t_status                 r_status;
    logic [OFF_OUT_W-1:0]    r_offset;
    logic [USED_W-1:0]       r_used;

    logic [ROW_W-1:0]        mem [ROWS];

    logic [S-1:0]            rd_valid;
    logic [S-1:0][KEY_W-1:0] rd_keys;
    logic [S-1:0][OFF_W-1:0] rd_offs;
    logic [S-1:0]            n_valid;
    logic [S-1:0][KEY_W-1:0] n_keys;
    logic [S-1:0][OFF_W-1:0] n_offs;

    t_scan_flags             scan_flags;
    logic [OFF_W-1:0]        hit_offset;
    logic [IDX_W-1:0]        free_idx;

    logic                    accept;
    logic                    mem_we;
    logic [HASH_BITS-1:0]    mem_waddr;
    logic [ROW_W-1:0]        mem_wdata;
    logic                    do_insert;
    t_status                 n_status;
    logic [OFF_W-1:0]        n_offset;
    logic [FP_W-1:0]         n_fp;
    logic [SUM_W-1:0]        alloc_end;
    logic [31:0]             off_wide;
    logic [31:0]             fp_wide;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign {rd_offs, rd_keys, rd_valid} = r_rd_row;

    bcnt_scan #(
        .SLOTS (S),
        .OFF_W (OFF_W),
        .IDX_W (IDX_W)
    ) u_scan (
        .i_valid      (rd_valid),
        .i_keys       (rd_keys),
        .i_offs       (rd_offs),
        .i_key        (r_key),
        .o_flags      (scan_flags),
        .o_hit_offset (hit_offset),
        .o_free_idx   (free_idx)
    );

    assign alloc_end = SUM_W'(r_fp) + SUM_W'(r_len) + SUM_W'(1);

    always_comb begin
        n_status  = ST_NOT_FOUND;
        n_offset  = '0;
        do_insert = 1'b0;
        if (r_enable) begin
            priority if (r_cmd == CMD_LOOKUP) begin
                if (scan_flags.hit) begin
                    n_status = ST_FOUND;
                    n_offset = hit_offset;
                end
            end else if (r_key == '0) begin
                n_status = ST_ZERO_KEY;
            end else if (scan_flags.hit) begin
                n_status = ST_FOUND;
                n_offset = hit_offset;
            end else if (!scan_flags.free_found) begin
                n_status = ST_BUCKET_FULL;
            end else if (alloc_end > SUM_W'(NAME_STORE_BYTES)) begin
                n_status = ST_STORE_FULL;
            end else begin
                n_status  = ST_INSERTED;
                n_offset  = OFF_W'(r_fp);
                do_insert = 1'b1;
            end
        end
    end

    assign n_fp     = do_insert ? FP_W'(alloc_end) : r_fp;
    assign off_wide = 32'(n_offset);
    assign fp_wide  = 32'(n_fp);

    always_comb begin
        n_valid           = rd_valid;
        n_keys            = rd_keys;
        n_offs            = rd_offs;
        n_valid[free_idx] = 1'b1;
        n_keys[free_idx]  = r_key;
        n_offs[free_idx]  = OFF_W'(r_fp);
    end

    assign mem_we    = (r_state == S_CLEAR) || ((r_state == S_CHECK) && do_insert);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_row : r_key[HASH_BITS-1:0];
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : {n_offs, n_keys, n_valid};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_row <= mem[i_key[HASH_BITS-1:0]];
            r_cmd    <= i_cmd;
            r_key    <= i_key;
            r_len    <= i_name_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_row <= '0;
            r_fp      <= '0;
            r_strobe  <= 1'b0;
            r_status  <= ST_NOT_FOUND;
            r_offset  <= '0;
            r_used    <= '0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_row <= r_clr_row + 1'b1;
                    if (r_clr_row == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_fp     <= n_fp;
                    r_strobe <= 1'b1;
                    r_status <= n_status;
                    r_offset <= off_wide[OFF_OUT_W-1:0];
                    r_used   <= fp_wide[USED_W-1:0];
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_name_offset = r_offset;
    assign o_store_used  = r_used;

    a_strobe_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == S_CHECK))
        else $error("result beat without a preceding check cycle");

    a_fp_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_fp) <= SUM_W'(NAME_STORE_BYTES))
        else $error("fill pointer beyond name store size");

    a_fp_moves_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_status != ST_INSERTED)) |-> $stable(r_fp))
        else $error("fill pointer moved without an insert");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("bucket memory written while idle");

endmodule
